### hw/rtl/bts_pkg.sv
package bts_pkg;

	localparam int MAX_DIM      = 256;
	localparam int COORD_BITS   = 16;
	localparam int WEIGHT_BITS  = 8;
	localparam int DIM_W        = 9;
	localparam int IDX_W        = $clog2(MAX_DIM);
	localparam int ADDR_W       = 2 * IDX_W;
	localparam int CH_W         = 8;
	localparam int TEXEL_W      = 3 * CH_W;
	localparam int OUT_W        = 16;
	localparam int PROD_W       = COORD_BITS + DIM_W;
	localparam int LIN_W        = CH_W + WEIGHT_BITS + 1;
	localparam int SUM_W        = LIN_W + WEIGHT_BITS + 1;
	localparam int SUM_SHIFT    = 2 * WEIGHT_BITS - 8;
	localparam int CMD_Q_DEPTH  = 4;
	localparam int OUT_Q_DEPTH  = 8;
	localparam int RAM_DEPTH    = MAX_DIM * MAX_DIM;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic                   is_wr;
		logic                   wr_ok;
		logic [ADDR_W-1:0]      a00;
		logic [ADDR_W-1:0]      a01;
		logic [ADDR_W-1:0]      a10;
		logic [ADDR_W-1:0]      a11;
		logic [TEXEL_W-1:0]     texel;
		logic [WEIGHT_BITS-1:0] fx;
		logic [WEIGHT_BITS-1:0] fy;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0] blue;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] red;
	} pix_t;

	// a*(S-f) + b*f
	function automatic logic [LIN_W-1:0] lerp(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b, input logic [WEIGHT_BITS-1:0] f);
		logic [WEIGHT_BITS:0] inv;
		inv = (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - (WEIGHT_BITS+1)'(f);
		return LIN_W'(a) * LIN_W'(inv) + LIN_W'(b) * LIN_W'(f);
	endfunction

endpackage

### hw/rtl/bts_ram.sv
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

### hw/rtl/bts_front.sv
module bts_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [bts_pkg::ADDR_W-1:0]      texel_index,
	input  logic [bts_pkg::TEXEL_W-1:0]     texel,
	input  logic [bts_pkg::COORD_BITS-1:0]  u_coord,
	input  logic [bts_pkg::COORD_BITS-1:0]  v_coord,
	input  logic [bts_pkg::DIM_W-1:0]       eff_w,
	input  logic [bts_pkg::DIM_W-1:0]       eff_h,
	input  logic                            q_full,
	output logic                            push,
	output bts_pkg::cmd_t                   cmd
);
	import bts_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic                  act_s1, act_s2;
	logic                  ok_s1, ok_s2;
	logic [ADDR_W-1:0]     idx_s1, idx_s2;
	logic [TEXEL_W-1:0]    texel_s1, texel_s2;
	logic [PROD_W-1:0]     tu_s1, tv_s1;
	logic [IDX_W-1:0]      c0_s2, c1_s2, r0_s2, r1_s2;
	logic [WEIGHT_BITS-1:0] fx_s2, fy_s2;
	cmd_t                  cmd_s3;

	logic [PROD_W-1:0]     tu_c, tv_c;
	logic [2*DIM_W-1:0]    area_c;
	logic                  ok_c;
	logic [DIM_W-1:0]      ipu, ipv;
	logic [IDX_W-1:0]      c0_c, c1_c, r0_c, r1_c;
	logic [ADDR_W:0]       row0_c, row1_c;
	cmd_t                  cmd_c;

	// front stalls only when its last stage cannot enter the queue
	assign en       = !(v_s3 && q_full);
	assign in_ready = en;
	assign push     = v_s3 && en;
	assign cmd      = cmd_s3;

	// half-texel offset folded in: x = u*W - 0.5 + 1
	assign tu_c   = PROD_W'(u_coord) * PROD_W'(eff_w) + PROD_W'(1 << (COORD_BITS - 1));
	assign tv_c   = PROD_W'(v_coord) * PROD_W'(eff_h) + PROD_W'(1 << (COORD_BITS - 1));
	assign area_c = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
	assign ok_c   = (2*DIM_W)'(texel_index) < area_c;

	assign ipu = tu_s1[PROD_W-1:COORD_BITS];
	assign ipv = tv_s1[PROD_W-1:COORD_BITS];

	always_comb begin
		c0_c = (ipu == '0) ? IDX_W'(eff_w - 1'b1) : IDX_W'(ipu - 1'b1);
		c1_c = (ipu >= eff_w) ? '0 : IDX_W'(ipu);
		r0_c = (ipv == '0) ? IDX_W'(eff_h - 1'b1) : IDX_W'(ipv - 1'b1);
		r1_c = (ipv >= eff_h) ? '0 : IDX_W'(ipv);
	end

	assign row0_c = (ADDR_W+1)'(r0_s2) * (ADDR_W+1)'(eff_w);
	assign row1_c = (ADDR_W+1)'(r1_s2) * (ADDR_W+1)'(eff_w);

	always_comb begin
		cmd_c.is_wr = (act_s2 == ACT_WRITE);
		cmd_c.wr_ok = ok_s2;
		cmd_c.texel = texel_s2;
		cmd_c.fx    = fx_s2;
		cmd_c.fy    = fy_s2;
		cmd_c.a01   = ADDR_W'(row0_c + (ADDR_W+1)'(c1_s2));
		cmd_c.a10   = ADDR_W'(row1_c + (ADDR_W+1)'(c0_s2));
		cmd_c.a11   = ADDR_W'(row1_c + (ADDR_W+1)'(c1_s2));
		if (act_s2 == ACT_WRITE) begin
			cmd_c.a00 = idx_s2;
		end else begin
			cmd_c.a00 = ADDR_W'(row0_c + (ADDR_W+1)'(c0_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= action;
			ok_s1    <= ok_c;
			idx_s1   <= texel_index;
			texel_s1 <= texel;
			tu_s1    <= tu_c;
			tv_s1    <= tv_c;

			act_s2   <= act_s1;
			ok_s2    <= ok_s1;
			idx_s2   <= idx_s1;
			texel_s2 <= texel_s1;
			c0_s2    <= c0_c;
			c1_s2    <= c1_c;
			r0_s2    <= r0_c;
			r1_s2    <= r1_c;
			fx_s2    <= tu_s1[COORD_BITS-1 -: WEIGHT_BITS];
			fy_s2    <= tv_s1[COORD_BITS-1 -: WEIGHT_BITS];

			cmd_s3   <= cmd_c;
		end
	end
endmodule

### hw/rtl/bts_cmd_q.sv
module bts_cmd_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bts_pkg::cmd_t din,
	output logic          full,
	output logic          valid,
	output bts_pkg::cmd_t dout,
	input  logic          pop
);
	import bts_pkg::*;

	localparam int PW = $clog2(CMD_Q_DEPTH);

	cmd_t           mem_q [CMD_Q_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;

	assign full  = (cnt_q == (PW+1)'(CMD_Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !pop) else $error("command queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

### hw/rtl/bts_back.sv
module bts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bts_pkg::cmd_t cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output bts_pkg::pix_t out_pix
);
	import bts_pkg::*;

	localparam int PW = $clog2(OUT_Q_DEPTH);

	logic                   v_s4, v_s5;
	logic [WEIGHT_BITS-1:0] fx_s4, fy_s4, fy_s5;
	logic [LIN_W-1:0]       bot_s5 [3];
	logic [LIN_W-1:0]       top_s5 [3];
	logic [TEXEL_W-1:0]     t00, t01, t10, t11;
	logic [OUT_W-1:0]       res_c [3];
	logic [WEIGHT_BITS:0]   fy_inv;
	logic                   wr_en, pop_sample, out_hs;
	logic [PW:0]            credit_q;
	pix_t                   oq_q [OUT_Q_DEPTH];
	logic [PW-1:0]          owr_q, ord_q;
	logic [PW:0]            ocnt_q;
	pix_t                   pix_c;

	// a sample needs a free output slot for everything still in flight
	assign pop        = cmd_valid && (cmd.is_wr || (credit_q < (PW+1)'(OUT_Q_DEPTH)));
	assign pop_sample = pop && !cmd.is_wr;
	assign wr_en      = pop && cmd.is_wr && cmd.wr_ok;
	assign out_hs     = out_valid && out_ready;

	bts_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_ram_top (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (cmd.a00),
		.wdata   (cmd.texel),
		.raddr_a (cmd.a00),
		.raddr_b (cmd.a01),
		.rdata_a (t00),
		.rdata_b (t01)
	);

	bts_ram #(.WIDTH(TEXEL_W), .DEPTH(RAM_DEPTH)) u_ram_bot (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (cmd.a00),
		.wdata   (cmd.texel),
		.raddr_a (cmd.a10),
		.raddr_b (cmd.a11),
		.rdata_a (t10),
		.rdata_b (t11)
	);

	assign fy_inv = (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - (WEIGHT_BITS+1)'(fy_s5);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			res_c[ch] = OUT_W'((SUM_W'(bot_s5[ch]) * SUM_W'(fy_inv)
				+ SUM_W'(top_s5[ch]) * SUM_W'(fy_s5)) >> SUM_SHIFT);
		end
		pix_c.red   = res_c[0];
		pix_c.green = res_c[1];
		pix_c.blue  = res_c[2];
	end

	always_ff @(posedge clk) begin
		fx_s4 <= cmd.fx;
		fy_s4 <= cmd.fy;
		fy_s5 <= fy_s4;
		for (int ch = 0; ch < 3; ch++) begin
			bot_s5[ch] <= lerp(t00[TEXEL_W-1-CH_W*ch -: CH_W],
				t01[TEXEL_W-1-CH_W*ch -: CH_W], fx_s4);
			top_s5[ch] <= lerp(t10[TEXEL_W-1-CH_W*ch -: CH_W],
				t11[TEXEL_W-1-CH_W*ch -: CH_W], fx_s4);
		end
		if (v_s5) begin
			oq_q[owr_q] <= pix_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			credit_q <= '0;
			owr_q    <= '0;
			ord_q    <= '0;
			ocnt_q   <= '0;
		end else begin
			v_s4     <= pop_sample;
			v_s5     <= v_s4;
			credit_q <= credit_q + (PW+1)'(pop_sample) - (PW+1)'(out_hs);
			if (v_s5) owr_q <= owr_q + 1'b1;
			if (out_hs) ord_q <= ord_q + 1'b1;
			ocnt_q   <= ocnt_q + (PW+1)'(v_s5) - (PW+1)'(out_hs);
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign out_pix   = oq_q[ord_q];

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= (PW+1)'(OUT_Q_DEPTH)) else $error("credit overrun");
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(ocnt_q == (PW+1)'(OUT_Q_DEPTH)) |-> !v_s5) else $error("output queue overflow");
	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= credit_q) else $error("result without credit");
	a_sample_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pop_sample |=> ##1 v_s5) else $error("sample lost in back pipeline");
endmodule

### hw/rtl/bilinear_texture_sampler_wrap.sv
// Path: an accepted sample transaction goes through front stages s1-s3, the command queue,
// the RAM read (s4), the lerp stage (s5) and the output queue to the master side; write transactions produce no result.
// Throughput: one transaction per cycle when nothing stalls, set by the two dual-read texel RAMs
// that fetch all four neighbors at once and a fully pipelined blend.
// Reset: arst_n clears queues, pipeline valids and sets width and height to
// 256; texel RAM contents are undefined until written.
module bilinear_texture_sampler_wrap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // texel_index, red_in, green_in, blue_in, u_coord, v_coord
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // red_out, green_out, blue_out
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [8:0]  cfg_data
);
	import bts_pkg::*;

	logic [DIM_W-1:0] w_q, h_q, eff_w, eff_h;
	logic             q_full, push, q_valid, pop;
	cmd_t             cmd_in, cmd_out;
	pix_t             pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= DIM_W'(MAX_DIM);
			h_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  w_q <= cfg_data;
				REG_HEIGHT: h_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// saturate sizes into 1..MAX_DIM
	assign eff_w = (w_q == '0) ? DIM_W'(1) : ((w_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : w_q);
	assign eff_h = (h_q == '0) ? DIM_W'(1) : ((h_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_q);

	// texel is stored red in the top byte, blue in the bottom byte
	bts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.action      (s_axis_tuser),
		.texel_index (s_axis_tdata[15:0]),
		.texel       ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
		.u_coord     (s_axis_tdata[55:40]),
		.v_coord     (s_axis_tdata[71:56]),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.q_full      (q_full),
		.push        (push),
		.cmd         (cmd_in)
	);

	bts_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (q_full),
		.valid  (q_valid),
		.dout   (cmd_out),
		.pop    (pop)
	);

	bts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (cmd_out),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (pix)
	);

	assign m_axis_tdata = {pix.blue, pix.green, pix.red};
endmodule

### tb/sv/tb_bilinear_texture_sampler_wrap.sv
module tb_bilinear_texture_sampler_wrap;
	import bts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;  // texel_index, red_in, green_in, blue_in, u_coord, v_coord
	logic        s_axis_tuser;  // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // red_out, green_out, blue_out
	logic        cfg_we;
	logic        cfg_idx;
	logic [8:0]  cfg_data;

	bilinear_texture_sampler_wrap dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// texture mirror and expected pixels
	logic [TEXEL_W-1:0] texels [RAM_DEPTH];
	bit                 texel_set [RAM_DEPTH];
	int unsigned        tex_w, tex_h;
	pix_t               pixel_q[$];
	int unsigned        idle_pct;
	int unsigned        errors;
	int unsigned        cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bilinear_texture_sampler_wrap: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= idle_pct);
	end

	function automatic int unsigned clamp_dim(input logic [8:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return 32'(v);
	endfunction

	// wrapped neighbor indices and weight along one axis
	function automatic void axis_map(input logic [15:0] c, input int unsigned size,
		output int unsigned i0, output int unsigned i1, output logic [7:0] f);
		longint unsigned t;
		int unsigned ip;
		t = 64'(c) * 64'(size) + 64'd32768;
		ip = 32'(t >> 16);
		f = t[15:8];
		i0 = (ip == 0) ? size - 1 : ip - 1;
		i1 = (ip >= size) ? 0 : ip;
	endfunction

	function automatic pix_t blend_pixel(input logic [15:0] u, input logic [15:0] v);
		int unsigned c0, c1, r0, r1, sh;
		logic [7:0] fx, fy;
		logic [23:0] t00, t01, t10, t11;
		longint unsigned a, b, c, d, sum;
		logic [15:0] ch [3];
		pix_t p;
		axis_map(u, tex_w, c0, c1, fx);
		axis_map(v, tex_h, r0, r1, fy);
		t00 = texels[r0 * tex_w + c0];
		t01 = texels[r0 * tex_w + c1];
		t10 = texels[r1 * tex_w + c0];
		t11 = texels[r1 * tex_w + c1];
		for (int k = 0; k < 3; k++) begin
			sh = 16 - 8 * k;
			a = 64'((t00 >> sh) & 24'hFF);
			b = 64'((t01 >> sh) & 24'hFF);
			c = 64'((t10 >> sh) & 24'hFF);
			d = 64'((t11 >> sh) & 24'hFF);
			sum = (a * (256 - fx) + b * fx) * (256 - fy) + (c * (256 - fx) + d * fx) * fy;
			ch[k] = 16'(sum >> 8);
		end
		p.red = ch[0];
		p.green = ch[1];
		p.blue = ch[2];
		return p;
	endfunction

	task automatic send_item(input logic act, input logic [15:0] idx, input logic [23:0] rgb,
		input logic [15:0] u, input logic [15:0] v);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {v, u, rgb[7:0], rgb[15:8], rgb[23:16], idx};
		do @(posedge clk); while (!s_axis_tready);
		if (act == ACT_SAMPLE)
			pixel_q.push_back(blend_pixel(u, v));
		else if (idx < tex_w * tex_h) begin
			texels[idx] = rgb;
			texel_set[idx] = 1'b1;
		end
	endtask

	task automatic write_texel(input logic [15:0] idx);
		send_item(ACT_WRITE, idx, 24'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// fill any unwritten neighbor first, then sample
	task automatic sample_at(input logic [15:0] u, input logic [15:0] v);
		int unsigned c0, c1, r0, r1;
		int unsigned cols [2];
		int unsigned rows [2];
		logic [7:0] f;
		axis_map(u, tex_w, c0, c1, f);
		axis_map(v, tex_h, r0, r1, f);
		cols = '{c0, c1};
		rows = '{r0, r1};
		foreach (rows[i])
			foreach (cols[j])
				if (!texel_set[rows[i] * tex_w + cols[j]])
					write_texel(16'(rows[i] * tex_w + cols[j]));
		send_item(ACT_SAMPLE, 16'($urandom), 24'($urandom), u, v);
	endtask

	task automatic set_size(input logic [8:0] w, input logic [8:0] h);
		s_axis_tvalid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_idx <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		tex_w = clamp_dim(w);
		tex_h = clamp_dim(h);
	endtask

	always @(posedge clk) begin
		pix_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pixel_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pixel %h", got);
			end else begin
				want = pixel_q.pop_front();
				if (got.red !== want.red || got.green !== want.green
					|| got.blue !== want.blue) begin
					errors++;
					if (errors <= 10)
						$display("pixel mismatch: expected r %h g %h b %h, got r %h g %h b %h",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
	end

	task automatic test_directed();
		// zero acts as one: single texel, every sample returns it
		set_size(9'd0, 9'd0);
		send_item(ACT_WRITE, 16'd0, 24'hFF00FF, 16'h0, 16'h0);
		send_item(ACT_WRITE, 16'd1, 24'h123456, 16'h0, 16'h0);
		send_item(ACT_WRITE, 16'hFFFF, 24'hABCDEF, 16'h0, 16'h0);
		sample_at(16'h0000, 16'h0000);
		sample_at(16'hFFFF, 16'hFFFF);
		// oversize acts as the maximum; hit the far corners with wrap
		set_size(9'd511, 9'd2);
		send_item(ACT_WRITE, 16'd255, 24'hFFFFFF, 16'h0, 16'h0);
		send_item(ACT_WRITE, 16'd511, 24'h000000, 16'h0, 16'h0);
		send_item(ACT_WRITE, 16'd512, 24'h777777, 16'h0, 16'h0);
		sample_at(16'h0000, 16'h0000);
		sample_at(16'hFFFF, 16'h0000);
		sample_at(16'h0000, 16'hFFFF);
		sample_at(16'hFFFF, 16'hFFFF);
		sample_at(16'h8000, 16'h8000);
		// resize: old texels are read with the new width
		set_size(9'd3, 9'd5);
		sample_at(16'h5555, 16'hAAAA);
		sample_at(16'h0080, 16'hFF80);
		set_size(9'd256, 9'd1);
		sample_at(16'h7FFF, 16'h1234);
	endtask

	task automatic test_random(input int n);
		logic [15:0] u, v;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) idle_pct = 0;
			if (i == n / 2) idle_pct = 24;
			u = 16'($urandom);
			v = 16'($urandom);
			case ($urandom_range(9))
				0: write_texel(16'($urandom));
				1, 2: write_texel(16'($urandom_range(tex_w * tex_h - 1)));
				default: sample_at(u, v);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WIDTH;
		cfg_data = '0;
		idle_pct = 24;
		errors = 0;
		cycles = 0;
		tex_w = MAX_DIM;
		tex_h = MAX_DIM;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_random(20);
		test_directed();
		set_size(9'd4, 9'd4);
		test_random(80);
		set_size(9'd1, 9'd256);
		test_random(40);
		set_size(9'd17, 9'd9);
		test_random(80);
		set_size(9'd256, 9'd256);
		test_random(30);
		s_axis_tvalid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_bilinear_texture_sampler_wrap: done, clean");
		else
			$display("tb_bilinear_texture_sampler_wrap: done, errors");
		$finish;
	end

endmodule
